@@ hdl/polynomial_term_store_evaluator_core_defines.svh @@
// Assertion macros shared by the polynomial term store evaluator RTL.
`ifndef POLYNOMIAL_TERM_STORE_EVALUATOR_CORE_DEFINES_SVH
`define POLYNOMIAL_TERM_STORE_EVALUATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PTSE_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PTSE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PTSE_ASSERT(label, clk, rst, prop, msg)
`define PTSE_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ hdl/ptse_pkg.sv @@
// Types and constants of the polynomial term store evaluator.
package ptse_pkg;

  localparam int OP_W    = 2;
  localparam int COEF_W  = 16;
  localparam int EXP_W   = 3;
  localparam int X_W     = 8;
  localparam int STAT_W  = 2;
  localparam int VALUE_W = 64;
  localparam int POW_W   = 50;
  localparam int PROD_W  = COEF_W + POW_W;
  localparam int TERM_W  = COEF_W + EXP_W;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [2:0]        res_t;

  localparam op_t OP_ADD      = 2'd0;
  localparam op_t OP_REMOVE   = 2'd1;
  localparam op_t OP_CONTAINS = 2'd2;
  localparam op_t OP_EVAL     = 2'd3;

  localparam stat_t ST_OK   = 2'd0;
  localparam stat_t ST_FULL = 2'd1;
  localparam stat_t ST_MISS = 2'd2;
  localparam stat_t ST_SAT  = 2'd3;

  localparam res_t RES_OK    = 3'd0;
  localparam res_t RES_FULL  = 3'd1;
  localparam res_t RES_MISS  = 3'd2;
  localparam res_t RES_FOUND = 3'd3;
  localparam res_t RES_EVAL  = 3'd4;

  typedef struct packed {
    logic capture;
    logic write_term;
    logic free_term;
    logic pow_load;
    logic pow_step;
    logic mul;
    logic acc_add;
    logic finish;
    res_t result;
  } cmd_t;

  typedef struct packed {
    op_t  opcode;
    logic slot_valid;
    logic slot_match;
    logic pow_done;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/ptse_ram.sv @@
// Generic single write port, single read port RAM with registered read.
module ptse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ptse_ctrl.sv @@
// Sequencer: walks the term slots for each opcode and drives the datapath.
`include "polynomial_term_store_evaluator_core_defines.svh"

module ptse_ctrl
  import ptse_pkg::*;
#(
  parameter int TERM_SLOTS = 16,
  localparam int SLOT_W = (TERM_SLOTS > 1) ? $clog2(TERM_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sts_t              sts,
  output cmd_t              cmd,
  output logic [SLOT_W-1:0] slot
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_POW  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] slot_next;
  res_t              res, res_next;
  logic              last;

  assign last     = (slot == SLOT_W'(TERM_SLOTS - 1));
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    slot_next  = slot;
    res_next   = res;
    cmd        = '0;
    cmd.result = res;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          slot_next   = '0;
          state_next  = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        case (sts.opcode) inside
          OP_ADD: begin
            if (!sts.slot_valid) begin
              cmd.write_term = 1'b1;
              res_next       = RES_OK;
              state_next     = S_FIN;
            end else if (last) begin
              res_next   = RES_FULL;
              state_next = S_FIN;
            end else begin
              slot_next  = slot + 1'b1;
              state_next = S_RD;
            end
          end
          OP_REMOVE, OP_CONTAINS: begin
            if (sts.slot_match) begin
              cmd.free_term = (sts.opcode == OP_REMOVE);
              res_next      = RES_FOUND;
              state_next    = S_FIN;
            end else if (last) begin
              res_next   = (sts.opcode == OP_REMOVE) ? RES_MISS : RES_OK;
              state_next = S_FIN;
            end else begin
              slot_next  = slot + 1'b1;
              state_next = S_RD;
            end
          end
          default: begin
            if (sts.slot_valid) begin
              cmd.pow_load = 1'b1;
              state_next   = S_POW;
            end else if (last) begin
              res_next   = RES_EVAL;
              state_next = S_FIN;
            end else begin
              slot_next  = slot + 1'b1;
              state_next = S_RD;
            end
          end
        endcase
      end
      S_POW: begin
        if (sts.pow_done) begin
          state_next = S_MUL;
        end else begin
          cmd.pow_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_add = 1'b1;
        if (last) begin
          res_next   = RES_EVAL;
          state_next = S_FIN;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = S_RD;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
      res   <= RES_OK;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      res   <= res_next;
    end
  end

  `PTSE_ASSERT(a_accept_starts_scan, clk, rst, (in_valid && !in_stall) |=> (state == S_RD && slot == '0), "scan did not start at slot zero")
  `PTSE_ASSERT(a_pow_only_eval, clk, rst, (state == S_POW) |-> (sts.opcode == OP_EVAL), "power loop outside evaluate")
  `PTSE_ASSERT(a_finish_needs_room, clk, rst, cmd.finish |-> sts.out_free, "result issued into a full output register")

endmodule

@@ hdl/ptse_dp.sv @@
// Datapath: term store, valid bits, power and product units, accumulator, result register.
`include "polynomial_term_store_evaluator_core_defines.svh"

module ptse_dp
  import ptse_pkg::*;
#(
  parameter int TERM_SLOTS = 16,
  localparam int SLOT_W = (TERM_SLOTS > 1) ? $clog2(TERM_SLOTS) : 1,
  localparam int ACC_W  = PROD_W + 1 + $clog2(TERM_SLOTS) + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic [SLOT_W-1:0]         slot,
  input  logic [OP_W-1:0]           opcode,
  input  logic signed [COEF_W-1:0]  coefficient,
  input  logic [EXP_W-1:0]          exponent,
  input  logic signed [X_W-1:0]     x_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [STAT_W-1:0]         status,
  output logic signed [VALUE_W-1:0] value
);

  logic [TERM_SLOTS-1:0] term_valid;
  op_t                   op_q;
  logic [COEF_W-1:0]     coef_q;
  logic [EXP_W-1:0]      exp_q;
  logic [X_W-1:0]        x_q;
  logic [X_W-1:0]        x_mag;
  logic [TERM_W-1:0]     rdata;
  logic [COEF_W-1:0]     rd_coef;
  logic [EXP_W-1:0]      rd_exp;
  logic [COEF_W-1:0]     cmag_q;
  logic                  neg_q;
  logic [EXP_W-1:0]      pow_cnt;
  logic [POW_W-1:0]      pow_q;
  logic [POW_W+X_W-1:0]  pow_prod;
  logic [PROD_W-1:0]     prod_q;
  logic [ACC_W-1:0]      acc_q;
  logic [ACC_W-1:0]      term_ext;
  logic [ACC_W-VALUE_W:0] acc_hi;
  logic                  sat;

  ptse_ram #(
    .WIDTH (TERM_W),
    .DEPTH (TERM_SLOTS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write_term),
    .waddr (slot),
    .wdata ({coef_q, exp_q}),
    .raddr (slot),
    .rdata (rdata)
  );

  assign rd_coef  = rdata[TERM_W-1:EXP_W];
  assign rd_exp   = rdata[EXP_W-1:0];
  assign x_mag    = x_q[X_W-1] ? (~x_q + 1'b1) : x_q;
  assign pow_prod = pow_q * x_mag;
  assign term_ext = {{(ACC_W-PROD_W){1'b0}}, prod_q};
  assign acc_hi   = acc_q[ACC_W-1:VALUE_W-1];
  assign sat      = !((&acc_hi) || !(|acc_hi));

  assign sts.opcode     = op_q;
  assign sts.slot_valid = term_valid[slot];
  assign sts.slot_match = term_valid[slot] && (rd_coef == coef_q) && (rd_exp == exp_q);
  assign sts.pow_done   = (pow_cnt == '0);
  assign sts.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= '0;
    end else if (cmd.write_term) begin
      term_valid[slot] <= 1'b1;
    end else if (cmd.free_term) begin
      term_valid[slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= opcode;
      coef_q <= coefficient;
      exp_q  <= exponent;
      x_q    <= x_value;
      acc_q  <= '0;
    end else if (cmd.acc_add) begin
      acc_q <= neg_q ? (acc_q - term_ext) : (acc_q + term_ext);
    end
    if (cmd.pow_load) begin
      pow_q   <= POW_W'(1);
      pow_cnt <= rd_exp;
      cmag_q  <= rd_coef[COEF_W-1] ? (~rd_coef + 1'b1) : rd_coef;
      neg_q   <= rd_coef[COEF_W-1] ^ (x_q[X_W-1] & rd_exp[0]);
    end else if (cmd.pow_step) begin
      pow_q   <= pow_prod[POW_W-1:0];
      pow_cnt <= pow_cnt - 1'b1;
    end
    if (cmd.mul) begin
      prod_q <= cmag_q * pow_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found <= (cmd.result == RES_FOUND);
      case (cmd.result)
        RES_FULL: begin
          status <= ST_FULL;
          value  <= '0;
        end
        RES_MISS: begin
          status <= ST_MISS;
          value  <= '0;
        end
        RES_EVAL: begin
          if (sat) begin
            status <= ST_SAT;
            value  <= acc_q[ACC_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}}
                                     : {1'b0, {(VALUE_W-1){1'b1}}};
          end else begin
            status <= ST_OK;
            value  <= acc_q[VALUE_W-1:0];
          end
        end
        default: begin
          status <= ST_OK;
          value  <= '0;
        end
      endcase
    end
  end

  `PTSE_ASSERT(a_add_free_slot, clk, rst, cmd.write_term |-> !sts.slot_valid, "live slot written")
  `PTSE_ASSERT(a_free_matched, clk, rst, cmd.free_term |-> sts.slot_match, "free without match")
  `PTSE_ASSERT(a_out_finish, clk, rst, $rose(out_valid) |-> $past(cmd.finish), "stray result")

endmodule

@@ hdl/polynomial_term_store_evaluator_core.sv @@
// Top level of the polynomial term store evaluator.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_stall  | opcode, coefficient, exponent, x_value
//  output  | out_valid / out_stall| found, status, value
//
// Add and remove/contains scan the slots in order, each slot read then
// checked, and stop at the first free or matching slot respectively. Evaluate
// walks every slot and, for each live one, steps the shared power multiplier
// through the exponent, multiplies and accumulates. One transaction is in flight at a time.
// Reset empties the store at once; no clearing pass.
// A stalled result waits in the output register while the next item is taken.
module polynomial_term_store_evaluator_core
  import ptse_pkg::*;
#(
  parameter int TERM_SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [OP_W-1:0]           opcode,
  input  logic signed [COEF_W-1:0]  coefficient,
  input  logic [EXP_W-1:0]          exponent,
  input  logic signed [X_W-1:0]     x_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic [STAT_W-1:0]         status,
  output logic signed [VALUE_W-1:0] value
);

  localparam int SLOT_W = (TERM_SLOTS > 1) ? $clog2(TERM_SLOTS) : 1;

  cmd_t              cmd;
  sts_t              sts;
  logic [SLOT_W-1:0] slot;

  ptse_ctrl #(
    .TERM_SLOTS (TERM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd),
    .slot     (slot)
  );

  ptse_dp #(
    .TERM_SLOTS (TERM_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .slot        (slot),
    .opcode      (opcode),
    .coefficient (coefficient),
    .exponent    (exponent),
    .x_value     (x_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .status      (status),
    .value       (value)
  );

endmodule
